[sv/lcp_pkg.sv]
package lcp_pkg;

   localparam int CSR_INDEX_WIDTH = 4;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEFAULT_PERIOD = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PERIOD_LIMIT   = 4'd1;

   localparam logic [7:0] DEFAULT_PERIOD_RESET = 8'd20;
   localparam logic [7:0] PERIOD_LIMIT_RESET   = 8'd200;

   localparam int MODE_FILL_BIT     = 0;
   localparam int MODE_FORWARD_BIT  = 1;
   localparam int MODE_BACKWARD_BIT = 2;
   localparam int MODE_MIRROR_BIT   = 3;
   localparam int MODE_OPPOSED_BIT  = 4;

   localparam logic [4:0] MODE_RESET = 5'd1;

   localparam int SPEED_SLOWER_BIT  = 0;
   localparam int SPEED_FASTER_BIT  = 1;
   localparam int SPEED_RESTORE_BIT = 2;

   typedef struct packed {
      logic [31:0] wide;
      logic        dir;
      logic [7:0]  first_row;
      logic [7:0]  second_row;
   } pat_state_type;

endpackage

[sv/lcp_pattern.sv]
module lcp_pattern #(
   parameter int LEDS_PER_ROW = 5
) (
   input  lcp_pkg::pat_state_type pat_cur,
   input  logic [4:0]             mode,
   output lcp_pkg::pat_state_type pat_next
);
   import lcp_pkg::*;

   localparam logic [31:0] ROW_MASK = 32'((64'd1 << LEDS_PER_ROW) - 64'd1);
   localparam logic [31:0] DBL_MASK = 32'((64'd1 << (2 * LEDS_PER_ROW)) - 64'd1);
   localparam logic [7:0]  ROW_MASK8 = ROW_MASK[7:0];
   localparam logic [7:0]  ROW_TOP = 8'(32'd1 << (LEDS_PER_ROW - 1));

   logic [31:0] fill_up;
   logic [31:0] shl;
   logic [31:0] shr;
   logic [7:0]  first_up;
   logic [7:0]  first_dn;
   logic [7:0]  second_up;
   logic [7:0]  second_dn;

   assign fill_up   = {pat_cur.wide[30:0], 1'b1};
   assign shl       = {pat_cur.wide[30:0], 1'b0};
   assign shr       = {1'b0, pat_cur.wide[31:1]};
   assign first_up  = {pat_cur.first_row[6:0], 1'b0};
   assign first_dn  = {1'b0, pat_cur.first_row[7:1]};
   assign second_up = {pat_cur.second_row[6:0], 1'b0};
   assign second_dn = {1'b0, pat_cur.second_row[7:1]};

   always_comb begin
      pat_next = pat_cur;
      if (mode[MODE_FILL_BIT]) begin
         if (pat_cur.dir) begin
            if ((pat_cur.wide & DBL_MASK) == '0) begin
               pat_next.wide = 32'd1;
            end else begin
               pat_next.wide = fill_up;
               if (fill_up >= DBL_MASK) begin
                  pat_next.dir = 1'b0;
               end
            end
         end else begin
            pat_next.wide = shl;
            if ((shl & DBL_MASK) == '0) begin
               pat_next.dir = 1'b1;
            end
         end
      end else if (mode[MODE_FORWARD_BIT]) begin
         if (shl > DBL_MASK || shl == '0) begin
            pat_next.wide = 32'd1;
         end else begin
            pat_next.wide = shl;
         end
      end else if (mode[MODE_BACKWARD_BIT]) begin
         if (shr > DBL_MASK || shr == '0) begin
            pat_next.wide = DBL_MASK + 32'd1;
         end else begin
            pat_next.wide = shr;
         end
      end else if (mode[MODE_MIRROR_BIT]) begin
         if (pat_cur.first_row == '0) begin
            pat_next.first_row = 8'd1;
            pat_next.dir       = 1'b1;
         end else if (pat_cur.dir) begin
            pat_next.first_row = first_up;
            if (first_up >= ROW_TOP) begin
               pat_next.dir = 1'b0;
            end
         end else begin
            pat_next.first_row = first_dn;
            if (first_dn <= 8'd1) begin
               pat_next.dir = 1'b1;
            end
         end
         pat_next.second_row = pat_next.first_row;
      end else if (mode[MODE_OPPOSED_BIT]) begin
         if (pat_cur.first_row == '0 || pat_cur.second_row == '0 ||
             (pat_cur.second_row & ~ROW_MASK8) != '0) begin
            pat_next.first_row  = 8'd1;
            pat_next.second_row = ROW_TOP;
            pat_next.dir        = 1'b1;
         end else if (pat_cur.dir) begin
            pat_next.first_row  = first_up;
            pat_next.second_row = second_dn;
            if (first_up >= ROW_TOP) begin
               pat_next.dir = 1'b0;
            end
         end else begin
            pat_next.first_row  = first_dn;
            pat_next.second_row = second_up;
            if (first_dn <= 8'd1) begin
               pat_next.dir = 1'b1;
            end
         end
      end
      if (mode[MODE_FILL_BIT] || mode[MODE_FORWARD_BIT] || mode[MODE_BACKWARD_BIT]) begin
         pat_next.first_row  = 8'(pat_next.wide & ROW_MASK);
         pat_next.second_row = 8'((pat_next.wide >> LEDS_PER_ROW) & ROW_MASK);
      end
   end

endmodule

[sv/lcp_speed.sv]
module lcp_speed (
   input  logic [7:0] speed,
   input  logic [7:0] latch_cur,
   input  logic [7:0] period_cur,
   input  logic [7:0] period_limit,
   input  logic [7:0] default_period,
   output logic [7:0] latch_next,
   output logic [7:0] period_next
);
   import lcp_pkg::*;

   always_comb begin
      latch_next  = latch_cur;
      period_next = period_cur;
      if (latch_cur == '0) begin
         if (speed[SPEED_SLOWER_BIT]) begin
            if (period_cur < period_limit) begin
               period_next = period_cur + 8'd1;
            end
            latch_next = speed;
         end else if (speed[SPEED_FASTER_BIT]) begin
            if (period_cur > 8'd1) begin
               period_next = period_cur - 8'd1;
            end
            latch_next = speed;
         end else if (speed[SPEED_RESTORE_BIT]) begin
            period_next = default_period;
            latch_next  = speed;
         end
      end else if (speed == '0) begin
         latch_next = '0;
      end
   end

endmodule

[sv/led_chaser_pattern_generator.sv]
// LED chaser pattern generator, Knight Rider style.
// req_ channel: one transfer per sync tick, carrying the speed button byte
// and two mode button bytes. rsp_ channel: one transfer per tick with both
// LED row bytes and a flag that is set when the pattern advanced on that tick.
// csr_ channel: register writes (index 0 default period, index 1 period
// limit); always ready, writes to other indexes are dropped. Write only
// while no tick is in flight.
// A tick accepted into the input register is processed into the result
// register and offered from there. Throughput: one tick per cycle while
// rsp_stall is low; the pattern, countdown and speed state are all
// computed combinationally between the input and result registers.
// Reset (synchronous, active high): empties both registers, pattern dark,
// fill-up mode, period 20, limit 200, countdown zero so the first tick steps.
// rsp_stall holds the result register; req_stall follows it in the same
// cycle while the input register holds a tick, so an empty input register
// takes at most one further tick before req_stall rises until the result
// is taken.
module led_chaser_pattern_generator #(
   parameter int LEDS_PER_ROW = 5
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_speed_buttons,
   input  logic [7:0]                          req_mode_buttons_a,
   input  logic [7:0]                          req_mode_buttons_b,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [7:0]                          rsp_row_one,
   output logic [7:0]                          rsp_row_two,
   output logic                                rsp_stepped,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lcp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [7:0]                          csr_wdata
);
   import lcp_pkg::*;

   logic          in_valid_ff;
   logic [7:0]    in_speed_ff;
   logic [7:0]    in_mode_a_ff;
   logic [7:0]    in_mode_b_ff;
   logic          rsp_valid_ff;
   logic [7:0]    row_one_ff;
   logic [7:0]    row_two_ff;
   logic          stepped_ff;
   pat_state_type pat_ff;
   pat_state_type pat_in;
   pat_state_type pat_step;
   logic [4:0]    mode_ff;
   logic [4:0]    mode_in;
   logic [4:0]    sel;
   logic [7:0]    countdown_ff;
   logic [7:0]    countdown_in;
   logic [7:0]    period_ff;
   logic [7:0]    period_in;
   logic [7:0]    latch_ff;
   logic [7:0]    latch_in;
   logic [7:0]    default_period_ff;
   logic [7:0]    period_limit_ff;
   logic          move;
   logic          fire;
   logic          step_now;

   assign move      = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && move;
   assign req_stall = in_valid_ff && !move;
   assign csr_ready = 1'b1;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_row_one = row_one_ff;
   assign rsp_row_two = row_two_ff;
   assign rsp_stepped = stepped_ff;

   assign sel      = in_mode_a_ff[4:0] | in_mode_b_ff[4:0];
   assign mode_in  = (sel != '0) ? sel : mode_ff;
   assign step_now = countdown_ff <= 8'd1;

   lcp_pattern #(
      .LEDS_PER_ROW(LEDS_PER_ROW)
   ) u_pattern (
      .pat_cur (pat_ff),
      .mode    (mode_in),
      .pat_next(pat_step)
   );

   lcp_speed u_speed (
      .speed         (in_speed_ff),
      .latch_cur     (latch_ff),
      .period_cur    (period_ff),
      .period_limit  (period_limit_ff),
      .default_period(default_period_ff),
      .latch_next    (latch_in),
      .period_next   (period_in)
   );

   assign pat_in       = step_now ? pat_step : pat_ff;
   assign countdown_in = step_now ? period_ff : countdown_ff - 8'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_speed_ff  <= req_speed_buttons;
         in_mode_a_ff <= req_mode_buttons_a;
         in_mode_b_ff <= req_mode_buttons_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (move) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         row_one_ff <= pat_in.first_row;
         row_two_ff <= pat_in.second_row;
         stepped_ff <= step_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff       <= '0;
         mode_ff      <= MODE_RESET;
         countdown_ff <= '0;
         period_ff    <= DEFAULT_PERIOD_RESET;
         latch_ff     <= '0;
      end else if (fire) begin
         pat_ff       <= pat_in;
         mode_ff      <= mode_in;
         countdown_ff <= countdown_in;
         period_ff    <= period_in;
         latch_ff     <= latch_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         default_period_ff <= DEFAULT_PERIOD_RESET;
         period_limit_ff   <= PERIOD_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DEFAULT_PERIOD: default_period_ff <= csr_wdata;
            CSR_PERIOD_LIMIT:   period_limit_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("result register not empty after reset");

   a_mode_nonzero: assert property (@(posedge clock) disable iff (reset) mode_ff != '0)
      else $error("mode register cleared");

   a_reload: assert property (@(posedge clock) disable iff (reset)
      (fire && step_now) |=> countdown_ff == $past(period_ff))
      else $error("countdown not reloaded from period on a step");

   a_stepped_flag: assert property (@(posedge clock) disable iff (reset)
      fire |=> stepped_ff == $past(step_now))
      else $error("stepped flag does not match countdown");

endmodule
